FILE: rtl/tcm_pkg.sv
// ============================================================================
// tcm_pkg
// shared types and constants for the triangle classify and measure core
// ============================================================================
`timescale 1ns / 1ps

package tcm_pkg;

    localparam int SIDE_BITS  = 16;
    localparam int PERIM_BITS = SIDE_BITS + 2;
    localparam int DIFF_BITS  = SIDE_BITS + 1;
    localparam int SQ_BITS    = 2 * SIDE_BITS;
    localparam int U_BITS     = PERIM_BITS + DIFF_BITS;
    localparam int V_BITS     = 2 * DIFF_BITS;
    localparam int VH_BITS    = V_BITS - DIFF_BITS;
    localparam int PP_BITS    = U_BITS + DIFF_BITS;
    localparam int ROOT_W     = 2 * SIDE_BITS + 1;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int REM_W      = ROOT_W + 3;

    localparam logic [1:0] SIDE_SCALENE     = 2'd0;
    localparam logic [1:0] SIDE_EQUILATERAL = 2'd1;
    localparam logic [1:0] SIDE_ISOSCELES   = 2'd2;

    localparam logic [1:0] ANGLE_RIGHT  = 2'd0;
    localparam logic [1:0] ANGLE_OBTUSE = 2'd1;
    localparam logic [1:0] ANGLE_ACUTE  = 2'd2;

    typedef struct packed {
        logic [SIDE_BITS-1:0] side_a;
        logic [SIDE_BITS-1:0] side_b;
        logic [SIDE_BITS-1:0] side_c;
    } req_t;

    typedef struct packed {
        logic                  is_valid;
        logic [1:0]            side_kind;
        logic [1:0]            angle_kind;
        logic [PERIM_BITS-1:0] perimeter;
        logic [ROOT_W-1:0]     area_times_four;
    } rsp_t;

    typedef struct packed {
        logic                  is_valid;
        logic [1:0]            side_kind;
        logic [1:0]            angle_kind;
        logic [PERIM_BITS-1:0] perimeter;
    } meta_t;

    typedef struct packed {
        meta_t              meta;
        logic [RAD_W-1:0]   rad;
        logic [REM_W-1:0]   rem;
        logic [ROOT_W-1:0]  root;
    } sqrt_stage_t;

endpackage

FILE: rtl/triangle_classify_measure_core.sv
// ============================================================================
// triangle_classify_measure_core
// triangle validity, side and angle class, perimeter and heron area
// ============================================================================
`timescale 1ns / 1ps

// Takes one beat of three unsigned 16-bit sides per cycle and returns one
// result beat per input, in order, through five front stages (sort, squares
// and the heron product split over two multiplier stages), then a chain of
// 33 square root cells, one root bit per cell. The whole pipe moves as one:
// it stalls only while a result beat waits at the output and the receiver
// stalls, and otherwise it takes one beat per cycle. Invalid triangles return zero
// in every field.

module triangle_classify_measure_core
    import tcm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    // global advance: hold everything while the output beat is not taken
    logic        en;
    logic        chain_vld [0:ROOT_W];
    sqrt_stage_t chain     [0:ROOT_W];

    assign en        = !(rsp_valid && rsp_stall);
    assign req_stall = !en;

    // front end feeds cell zero of the root chain
    tcm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .req_valid (req_valid),
        .req       (req),
        .out_vld   (chain_vld[0]),
        .out_stage (chain[0])
    );

    // one cell per root bit, most significant first
    for (genvar g = 0; g < ROOT_W; g++)
    begin : g_cell
        tcm_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_vld    (chain_vld[g]),
            .in_stage  (chain[g]),
            .out_vld   (chain_vld[g+1]),
            .out_stage (chain[g+1])
        );
    end

    // last cell doubles as the output register
    assign rsp_valid           = chain_vld[ROOT_W];
    assign rsp.is_valid        = chain[ROOT_W].meta.is_valid;
    assign rsp.side_kind       = chain[ROOT_W].meta.side_kind;
    assign rsp.angle_kind      = chain[ROOT_W].meta.angle_kind;
    assign rsp.perimeter       = chain[ROOT_W].meta.perimeter;
    assign rsp.area_times_four = chain[ROOT_W].root;

    // invalid beats carry all zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.is_valid |->
            rsp.perimeter == '0 && rsp.area_times_four == '0
            && rsp.side_kind == SIDE_SCALENE && rsp.angle_kind == ANGLE_RIGHT)
        else $error("invalid triangle beat with nonzero fields");

    // a valid triangle has positive perimeter and area
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.is_valid |->
            rsp.perimeter != '0 && rsp.area_times_four != '0)
        else $error("valid triangle with zero perimeter or area");

    // equilateral is always acute
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.side_kind == SIDE_EQUILATERAL |->
            rsp.angle_kind == ANGLE_ACUTE)
        else $error("equilateral triangle not acute");

endmodule

FILE: rtl/tcm_front.sv
// ============================================================================
// tcm_front
// classification, sort, squares and heron product ahead of the root chain
// ============================================================================
`timescale 1ns / 1ps

module tcm_front
    import tcm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        req_valid,
    input  req_t        req,
    output logic        out_vld,
    output sqrt_stage_t out_stage
);

    // stage a: captured sides
    logic                 a_vld_reg;
    req_t                 a_reg;

    // stage b
    logic                 b_vld_reg;
    meta_t                b_meta_reg;
    logic [PERIM_BITS-1:0] b_s_reg;
    logic [DIFF_BITS-1:0] b_x_reg, b_y_reg, b_z_reg;
    logic [SIDE_BITS-1:0] b_lo_reg, b_mid_reg, b_hi_reg;

    // stage c
    logic                 c_vld_reg;
    meta_t                c_meta_reg;
    logic [U_BITS-1:0]    c_u_reg;
    logic [V_BITS-1:0]    c_v_reg;
    logic [SQ_BITS-1:0]   c_sql_reg, c_sqm_reg, c_sqh_reg;

    // stage d
    logic                 d_vld_reg;
    meta_t                d_meta_reg;
    meta_t                d_meta_next;
    logic [PP_BITS-1:0]   d_pl_reg, d_ph_reg;

    // stage e
    logic                 e_vld_reg;
    meta_t                e_meta_reg;
    logic [RAD_W-1:0]     e_rad_reg;

    logic [DIFF_BITS-1:0] ab, bc, ac;
    logic                 tri_ok;
    logic [1:0]           kind;
    logic [SIDE_BITS-1:0] s0_lo, s0_mid, s1_mid, s1_hi, s2_lo, s2_mid;
    logic [SQ_BITS:0]     sq_sum;
    logic [1:0]           angle;
    logic [PP_BITS+VH_BITS-1:0] rad_full;

    always_comb
    begin
        ab = {1'b0, a_reg.side_a} + {1'b0, a_reg.side_b};
        bc = {1'b0, a_reg.side_b} + {1'b0, a_reg.side_c};
        ac = {1'b0, a_reg.side_a} + {1'b0, a_reg.side_c};
        tri_ok = (ab > {1'b0, a_reg.side_c}) && (bc > {1'b0, a_reg.side_a})
                 && (ac > {1'b0, a_reg.side_b});
        if (a_reg.side_a == a_reg.side_b && a_reg.side_b == a_reg.side_c)
            kind = SIDE_EQUILATERAL;
        else if (a_reg.side_a == a_reg.side_b || a_reg.side_a == a_reg.side_c
                 || a_reg.side_b == a_reg.side_c)
            kind = SIDE_ISOSCELES;
        else
            kind = SIDE_SCALENE;
        // three compare and swap steps
        s0_lo  = (a_reg.side_a > a_reg.side_b) ? a_reg.side_b : a_reg.side_a;
        s0_mid = (a_reg.side_a > a_reg.side_b) ? a_reg.side_a : a_reg.side_b;
        s1_mid = (s0_mid > a_reg.side_c) ? a_reg.side_c : s0_mid;
        s1_hi  = (s0_mid > a_reg.side_c) ? s0_mid : a_reg.side_c;
        s2_lo  = (s0_lo > s1_mid) ? s1_mid : s0_lo;
        s2_mid = (s0_lo > s1_mid) ? s0_lo : s1_mid;
    end

    always_comb
    begin
        sq_sum = {1'b0, c_sql_reg} + {1'b0, c_sqm_reg};
        if (!c_meta_reg.is_valid)
            angle = ANGLE_RIGHT;
        else if ({1'b0, c_sqh_reg} == sq_sum)
            angle = ANGLE_RIGHT;
        else if ({1'b0, c_sqh_reg} > sq_sum)
            angle = ANGLE_OBTUSE;
        else
            angle = ANGLE_ACUTE;
        d_meta_next            = c_meta_reg;
        d_meta_next.angle_kind = angle;
        rad_full = {{VH_BITS{1'b0}}, d_pl_reg} + {d_ph_reg, {DIFF_BITS{1'b0}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg <= req_valid;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
            e_vld_reg <= d_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= req;

            b_meta_reg.is_valid   <= tri_ok;
            b_meta_reg.side_kind  <= tri_ok ? kind : SIDE_SCALENE;
            b_meta_reg.angle_kind <= ANGLE_RIGHT;
            b_meta_reg.perimeter  <= tri_ok ?
                ({2'b0, a_reg.side_a} + {1'b0, bc}) : '0;
            b_s_reg  <= tri_ok ? ({2'b0, a_reg.side_a} + {1'b0, bc}) : '0;
            b_x_reg  <= bc - {1'b0, a_reg.side_a};
            b_y_reg  <= ac - {1'b0, a_reg.side_b};
            b_z_reg  <= ab - {1'b0, a_reg.side_c};
            b_lo_reg <= s2_lo;
            b_mid_reg <= s2_mid;
            b_hi_reg <= s1_hi;

            c_meta_reg <= b_meta_reg;
            c_u_reg    <= b_s_reg * b_x_reg;
            c_v_reg    <= b_y_reg * b_z_reg;
            c_sql_reg  <= b_lo_reg * b_lo_reg;
            c_sqm_reg  <= b_mid_reg * b_mid_reg;
            c_sqh_reg  <= b_hi_reg * b_hi_reg;

            d_meta_reg <= d_meta_next;
            d_pl_reg <= c_u_reg * c_v_reg[DIFF_BITS-1:0];
            d_ph_reg <= c_u_reg * c_v_reg[V_BITS-1:DIFF_BITS];

            e_meta_reg <= d_meta_reg;
            e_rad_reg  <= rad_full[RAD_W-1:0];
        end
    end

    assign out_vld         = e_vld_reg;
    assign out_stage.meta  = e_meta_reg;
    assign out_stage.rad   = e_rad_reg;
    assign out_stage.rem   = '0;
    assign out_stage.root  = '0;

endmodule

FILE: rtl/tcm_sqrt_cell.sv
// ============================================================================
// tcm_sqrt_cell
// one restoring square root digit, registered, passed to the next cell
// ============================================================================
`timescale 1ns / 1ps

module tcm_sqrt_cell
    import tcm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_vld,
    input  sqrt_stage_t in_stage,
    output logic        out_vld,
    output sqrt_stage_t out_stage
);

    logic        vld_reg;
    sqrt_stage_t stage_reg;
    logic [REM_W-1:0] rem_sh, trial;
    logic        take;
    sqrt_stage_t stage_next;

    always_comb
    begin
        rem_sh = {in_stage.rem[REM_W-3:0], in_stage.rad[RAD_W-1:RAD_W-2]};
        trial  = {1'b0, in_stage.root, 2'b01};
        take   = rem_sh >= trial;
        stage_next      = in_stage;
        stage_next.rad  = {in_stage.rad[RAD_W-3:0], 2'b00};
        stage_next.rem  = take ? (rem_sh - trial) : rem_sh;
        stage_next.root = {in_stage.root[ROOT_W-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            stage_reg <= stage_next;
    end

    assign out_vld   = vld_reg;
    assign out_stage = stage_reg;

endmodule

FILE: test/tb_top.sv
// ============================================================================
// tb_top
// checks triangle validity, side and angle class, perimeter and heron area
// ============================================================================
`timescale 1ns / 1ps

// Beats go in over a valid/stall channel and results come back in order. A
// directed table covers the extremes first, some with fixed results; a local
// model works out the others from the accepted sides. Random triangles follow,
// most of them valid and the rest degenerate, zero-sided or noise. Both
// sides idle at random, and once the sender drains the pipe on purpose.

module tb_top;
    import tcm_pkg::*;

    localparam int LATENCY   = 38;
    localparam int N_RANDOM  = 1430;
    localparam int WDOG_MAX  = 4000;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    // results still owed by the block, oldest first
    rsp_t pending_rsp[$];
    int   fail_count;
    int   idle_cycles;
    bit   stim_done;

    // directed row: sides, whether the result is typed in, and that result
    typedef struct {
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
        bit          fixed;
        rsp_t        want;
    } row_t;

    row_t dir_rows[$];

    triangle_classify_measure_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // floor of the square root of a product up to 66 bits
    function automatic logic [ROOT_W-1:0] isqrt_heron(input logic [71:0] prod);
        logic [71:0] root;
        logic [71:0] trial;
        root = '0;
        for (int bitpos = 35; bitpos >= 0; bitpos--)
        begin
            trial = root | (72'd1 << bitpos);
            if (trial * trial <= prod)
                root = trial;
        end
        return root[ROOT_W-1:0];
    endfunction

    // expected result for one triangle
    function automatic rsp_t measure_triangle(input req_t r);
        rsp_t        res;
        logic [19:0] a, b, c, lo, mid, hi, sw, per;
        logic [39:0] sq_lo_mid, sq_hi;
        logic [71:0] prod;
        res = '0;
        a = {4'b0, r.side_a};
        b = {4'b0, r.side_b};
        c = {4'b0, r.side_c};
        if (!(a + b > c && b + c > a && a + c > b))
            return res;
        res.is_valid = 1'b1;
        if (a == b && b == c)
            res.side_kind = SIDE_EQUILATERAL;
        else if (a == b || a == c || b == c)
            res.side_kind = SIDE_ISOSCELES;
        else
            res.side_kind = SIDE_SCALENE;
        lo = a; mid = b; hi = c;
        if (lo > mid) begin sw = lo; lo = mid; mid = sw; end
        if (mid > hi) begin sw = mid; mid = hi; hi = sw; end
        if (lo > mid) begin sw = lo; lo = mid; mid = sw; end
        sq_lo_mid = 40'(lo) * 40'(lo) + 40'(mid) * 40'(mid);
        sq_hi = 40'(hi) * 40'(hi);
        if (sq_hi == sq_lo_mid)
            res.angle_kind = ANGLE_RIGHT;
        else if (sq_hi > sq_lo_mid)
            res.angle_kind = ANGLE_OBTUSE;
        else
            res.angle_kind = ANGLE_ACUTE;
        per = a + b + c;
        res.perimeter = per[PERIM_BITS-1:0];
        prod = 72'(a + b + c) * 72'(b + c - a) * 72'(a + c - b) * 72'(a + b - c);
        res.area_times_four = isqrt_heron(prod);
        return res;
    endfunction

    function automatic row_t mk_row(input logic [15:0] a, input logic [15:0] b,
                                    input logic [15:0] c, input bit fixed,
                                    input rsp_t want);
        row_t r;
        r.a = a; r.b = b; r.c = c; r.fixed = fixed; r.want = want;
        return r;
    endfunction

    function automatic rsp_t mk_rsp(input logic v, input logic [1:0] sk,
                                    input logic [1:0] ak, input int unsigned per,
                                    input longint unsigned ar);
        rsp_t r;
        r.is_valid = v; r.side_kind = sk; r.angle_kind = ak;
        r.perimeter = PERIM_BITS'(per); r.area_times_four = ROOT_W'(ar);
        return r;
    endfunction

    // random sides: mostly valid triangles, some degenerate, some noise
    function automatic req_t random_triangle();
        req_t        r;
        int unsigned kind, lim, x, y;
        kind = $urandom_range(0, 9);
        lim = ($urandom_range(0, 3) == 0) ? 65535 : ($urandom_range(0, 1) ? 255 : 15);
        r.side_a = 16'($urandom_range(1, lim));
        r.side_b = 16'($urandom_range(1, lim));
        if (kind < 6)
        begin
            // third side strictly between difference and sum
            x = (r.side_a > r.side_b) ? r.side_a - r.side_b : r.side_b - r.side_a;
            y = r.side_a + r.side_b - 1;
            if (y > 65535)
                y = 65535;
            r.side_c = 16'($urandom_range(x + 1, y));
        end
        else if (kind == 6)
        begin
            r.side_b = r.side_a;
            r.side_c = ($urandom_range(0, 1)) ? r.side_a : 16'($urandom_range(1, lim));
        end
        else if (kind == 7)
            r.side_c = 16'(r.side_a + r.side_b);
        else if (kind == 8)
            r.side_c = ($urandom_range(0, 1)) ? 16'd0 : 16'($urandom_range(0, 65535));
        else
        begin
            r.side_a = 16'($urandom_range(0, 65535));
            r.side_b = 16'($urandom_range(0, 65535));
            r.side_c = 16'($urandom_range(0, 65535));
        end
        // rotate so that every position sees the odd side out
        case ($urandom_range(0, 2))
            1: r = {r.side_b, r.side_c, r.side_a};
            2: r = {r.side_c, r.side_a, r.side_b};
            default: ;
        endcase
        return r;
    endfunction

    function automatic int unsigned gap_len();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        else if (p < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 50);
    endfunction

    // sends one beat, waiting for acceptance, and records what it must give
    task automatic send_beat(input req_t r, input bit fixed, input rsp_t want);
        int unsigned gap;
        gap = gap_len();
        // valid drops for the gap so the last beat is not taken twice
        if (gap != 0)
            req_valid <= 1'b0;
        repeat (gap)
            @(posedge clk);
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        pending_rsp.push_back(fixed ? want : measure_triangle(r));
    endtask

    // stimulus
    initial
    begin
        req_t r;
        rsp_t z;
        z = '0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        stim_done = 1'b0;
        fail_count = 0;

        dir_rows.push_back(mk_row(16'd0, 16'd0, 16'd0, 1, z));
        dir_rows.push_back(mk_row(16'd0, 16'd5, 16'd5, 1, z));
        dir_rows.push_back(mk_row(16'd5, 16'd0, 16'd5, 1, z));
        dir_rows.push_back(mk_row(16'd5, 16'd5, 16'd0, 1, z));
        dir_rows.push_back(mk_row(16'd1, 16'd2, 16'd3, 1, z));
        dir_rows.push_back(mk_row(16'd3, 16'd1, 16'd2, 1, z));
        dir_rows.push_back(mk_row(16'd2, 16'd3, 16'd1, 1, z));
        dir_rows.push_back(mk_row(16'd1, 16'd1, 16'd65535, 1, z));
        dir_rows.push_back(mk_row(16'd65535, 16'd65535, 16'd0, 1, z));
        dir_rows.push_back(mk_row(16'd1, 16'd1, 16'd1, 1,
            mk_rsp(1, SIDE_EQUILATERAL, ANGLE_ACUTE, 3, 1)));
        dir_rows.push_back(mk_row(16'd3, 16'd4, 16'd5, 1,
            mk_rsp(1, SIDE_SCALENE, ANGLE_RIGHT, 12, 24)));
        dir_rows.push_back(mk_row(16'd5, 16'd3, 16'd4, 1,
            mk_rsp(1, SIDE_SCALENE, ANGLE_RIGHT, 12, 24)));
        dir_rows.push_back(mk_row(16'd4, 16'd5, 16'd3, 1,
            mk_rsp(1, SIDE_SCALENE, ANGLE_RIGHT, 12, 24)));
        dir_rows.push_back(mk_row(16'd65535, 16'd65535, 16'd65535, 1'b0, z));
        dir_rows.push_back(mk_row(16'd65535, 16'd65535, 16'd1, 1'b0, z));
        dir_rows.push_back(mk_row(16'd1, 16'd65535, 16'd65535, 1'b0, z));
        dir_rows.push_back(mk_row(16'd65534, 16'd65535, 16'd65533, 1'b0, z));
        dir_rows.push_back(mk_row(16'd2, 16'd2, 16'd3, 1'b0, z));
        dir_rows.push_back(mk_row(16'd5, 16'd5, 16'd8, 1'b0, z));
        dir_rows.push_back(mk_row(16'd7, 16'd9, 16'd7, 1'b0, z));
        dir_rows.push_back(mk_row(16'd4, 16'd6, 16'd7, 1'b0, z));
        dir_rows.push_back(mk_row(16'd43690, 16'd21845, 16'd43690, 1'b0, z));
        dir_rows.push_back(mk_row(16'd39321, 16'd52428, 16'd65535, 1'b0, z));

        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            r = {dir_rows[i].a, dir_rows[i].b, dir_rows[i].c};
            send_beat(r, dir_rows[i].fixed, dir_rows[i].want);
        end

        for (int n = 0; n < N_RANDOM; n++)
        begin
            // once mid-run let the pipe drain completely
            if (n == N_RANDOM / 2)
            begin
                req_valid <= 1'b0;
                while (pending_rsp.size() != 0)
                    @(posedge clk);
            end
            send_beat(random_triangle(), 1'b0, z);
        end
        req_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver stalls at random, with long runs of none
    initial
    begin
        int unsigned hold;
        rsp_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            hold = gap_len();
            if (hold != 0 && $urandom_range(0, 3) != 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold)
                    @(posedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: result beat with nothing expected: %p", $time, rsp);
                fail_count++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.is_valid !== want.is_valid)
                begin
                    $display("%0t: is_valid expected %0d got %0d",
                             $time, want.is_valid, rsp.is_valid);
                    fail_count++;
                end
                if (rsp.side_kind !== want.side_kind)
                begin
                    $display("%0t: side_kind expected %0d got %0d",
                             $time, want.side_kind, rsp.side_kind);
                    fail_count++;
                end
                if (rsp.angle_kind !== want.angle_kind)
                begin
                    $display("%0t: angle_kind expected %0d got %0d",
                             $time, want.angle_kind, rsp.angle_kind);
                    fail_count++;
                end
                if (rsp.perimeter !== want.perimeter)
                begin
                    $display("%0t: perimeter expected %0d got %0d",
                             $time, want.perimeter, rsp.perimeter);
                    fail_count++;
                end
                if (rsp.area_times_four !== want.area_times_four)
                begin
                    $display("%0t: area_times_four expected %0d got %0d",
                             $time, want.area_times_four, rsp.area_times_four);
                    fail_count++;
                end
            end
        end
    end

    // watchdog and end of run
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WDOG_MAX)
            begin
                $display("status: fail");
                $finish;
            end
            if (stim_done && pending_rsp.size() == 0)
            begin
                repeat (LATENCY + 10)
                    @(posedge clk);
                if (fail_count == 0 && pending_rsp.size() == 0)
                    $display("status: pass");
                else
                    $display("status: fail");
                $finish;
            end
        end
    end

endmodule
